// ----- rtl/lsc_pkg.sv -----
// Shared types, constants and the CRC-32 byte update for the soft-value slicer
// and trailing CRC check. No dependencies.
package lsc_pkg;

  localparam logic [31:0] CRC_POLY = 32'h04C1_1DB7;
  localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;
  localparam logic [2:0]  TAIL_FULL = 3'd4;
  localparam logic [2:0]  BIT_LAST = 3'd7;

  localparam logic [31:0] CHECK_ENABLE_RESET = 32'h0000_0001;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       frame_end;
    logic       crc_pass;
    logic       too_short;
  } res_t;

  // MSB-first CRC-32 update with one byte, eight bit steps.
  function automatic logic [31:0] crc_add_byte(input logic [31:0] crc_in,
                                               input logic [7:0]  data);
    logic [31:0] c;
    c = crc_in ^ {data, 24'h0};
    for (int k = 0; k < 8; k++) begin
      if (c[31]) begin
        c = {c[30:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[30:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// ----- rtl/lsc_cfg_regs.sv -----
// APB-style register port holding check_enable.
// Depends on lsc_pkg.
module lsc_cfg_regs (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output logic        check_enable
);
  import lsc_pkg::*;

  logic wr_en;

  // single register: every word address decodes to it
  assign wr_en  = psel && penable && pwrite && (paddr[1:0] == paddr[1:0]);
  assign pready = 1'b1;
  assign prdata = {31'h0, check_enable};

  always_ff @(posedge clk) begin
    if (rst) begin
      check_enable <= CHECK_ENABLE_RESET[0];
    end else if (wr_en) begin
      check_enable <= pwdata[0];
    end
  end

endmodule

// ----- rtl/lsc_frame_core.sv -----
// Frame state: bit packing, four-byte tail, CRC accumulator and the frame-end check.
// Depends on lsc_pkg.
module lsc_frame_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  logic              hard_bit,
  input  logic              last,
  input  logic              check_enable,
  output logic              has_result,
  output lsc_pkg::res_t     result
);
  import lsc_pkg::*;

  logic [31:0] crc_accum;
  logic [6:0]  partial_bits;
  logic [2:0]  bit_position;
  logic [31:0] tail_bytes;
  logic [2:0]  tail_fill;

  logic [7:0]  packed_bits;
  logic [7:0]  out_byte;
  logic        tail_full;
  logic [31:0] crc_next;
  logic [31:0] tail_next;
  logic [2:0]  fill_next;
  logic        short_frame;
  logic        pass;

  assign packed_bits = {partial_bits, hard_bit};
  assign has_result  = last || (bit_position == BIT_LAST);
  assign out_byte    = last ? (packed_bits << (BIT_LAST - bit_position)) : packed_bits;

  assign tail_full = (tail_fill == TAIL_FULL);
  assign crc_next  = tail_full ? crc_add_byte(crc_accum, tail_bytes[31:24]) : crc_accum;
  assign fill_next = tail_full ? tail_fill : tail_fill + 3'd1;
  assign tail_next = {tail_bytes[23:0], out_byte};

  assign short_frame = (fill_next < TAIL_FULL);

  always_comb begin
    if (!check_enable) begin
      pass = 1'b1;
    end else if (short_frame) begin
      pass = 1'b0;
    end else begin
      pass = ((crc_next ^ CRC_INIT) == tail_next);
    end
  end

  assign result.data_byte = out_byte;
  assign result.frame_end = last;
  assign result.crc_pass  = last && pass;
  assign result.too_short = last && short_frame;

  always_ff @(posedge clk) begin
    if (rst) begin
      crc_accum    <= CRC_INIT;
      partial_bits <= '0;
      bit_position <= '0;
      tail_bytes   <= '0;
      tail_fill    <= '0;
    end else if (step) begin
      if (last) begin
        crc_accum    <= CRC_INIT;
        partial_bits <= '0;
        bit_position <= '0;
        tail_bytes   <= '0;
        tail_fill    <= '0;
      end else if (has_result) begin
        crc_accum    <= crc_next;
        partial_bits <= '0;
        bit_position <= '0;
        tail_bytes   <= tail_next;
        tail_fill    <= fill_next;
      end else begin
        partial_bits <= packed_bits[6:0];
        bit_position <= bit_position + 3'd1;
      end
    end
  end

endmodule

// ----- rtl/llr_slice_crc32_check_unit.sv -----
// Top level: input register, frame core, result register and config port.
// Depends on lsc_pkg, lsc_cfg_regs, lsc_frame_core.
//
// Slices each signed soft value to a bit (negative is 1), packs bits MSB first
// into bytes and returns one result per completed byte; the frame's last byte,
// zero padded if partial, carries frame end. The CRC-32 (poly 04C11DB7, init
// all ones, inverted) runs over all bytes but the last four, which are compared
// with it at frame end. Throughput is one item per cycle unless the result
// register is stalled while the input register holds an item that completes a
// byte or ends the frame; such an item is then held, which stalls the input.
// The input register feeds the slice, pack and combinational CRC byte update
// straight into the result register. check_enable is sampled at frame end.
module llr_slice_crc32_check_unit (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic signed [7:0] soft_value,
  input  logic              frame_last,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [7:0]        data_byte,
  output logic              frame_end,
  output logic              crc_pass,
  output logic              too_short,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [1:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);
  import lsc_pkg::*;

  logic s1_valid;
  logic s1_bit;
  logic s1_last;
  logic check_enable;
  logic has_result;
  logic advance;
  res_t core_res;
  res_t out_res;

  lsc_cfg_regs u_cfg (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .check_enable (check_enable)
  );

  lsc_frame_core u_core (
    .clk          (clk),
    .rst          (rst),
    .step         (advance),
    .hard_bit     (s1_bit),
    .last         (s1_last),
    .check_enable (check_enable),
    .has_result   (has_result),
    .result       (core_res)
  );

  assign advance  = s1_valid && (!has_result || !out_valid || out_ready);
  assign in_ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_bit  <= soft_value[7];
      s1_last <= frame_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && has_result) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && has_result) begin
      out_res <= core_res;
    end
  end

  assign data_byte = out_res.data_byte;
  assign frame_end = out_res.frame_end;
  assign crc_pass  = out_res.crc_pass;
  assign too_short = out_res.too_short;

  a_last_gives_end: assert property (@(posedge clk) disable iff (rst)
    advance && s1_last |=> out_valid && frame_end)
    else $error("frame end item did not produce a frame_end result");

  a_mid_flags_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !frame_end |-> !crc_pass && !too_short)
    else $error("status flags set on a mid-frame result");

  a_short_fails: assert property (@(posedge clk) disable iff (rst)
    advance && s1_last && check_enable |=> !(too_short && crc_pass))
    else $error("short frame reported as passing with checking on");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !(advance && has_result))
    else $error("result register overwritten while stalled");

endmodule
